### sv/seven_segment_number_formatter_defines.svh
// Assertion macros used by the checker file of the number formatter.
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_DEFINES_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SSNF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssnf assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SSNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssnf assertion failed");

`endif

### sv/ssnf_pkg.sv
// Types, constants and the segment decoder of the number formatter.
package ssnf_pkg;

  localparam int unsigned NumDigits  = 4;
  localparam int unsigned MagW       = 14;   // holds magnitudes up to 9999
  localparam int unsigned QuotW      = 11;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned SegW       = 7;
  localparam int unsigned RecipW     = 16;
  localparam int unsigned ProdW      = MagW + RecipW;
  localparam int unsigned RecipShift = 19;

  localparam logic signed [15:0] MaxShown = 16'sd9999;
  localparam logic signed [15:0] MinShown = -16'sd999;

  // floor(x * 52429 / 2^19) equals floor(x / 10) for any 16-bit x
  localparam logic [RecipW-1:0] RecipTen = 16'd52429;

  localparam logic [SegW-1:0] SegMinus = 7'h40;
  localparam logic [SegW-1:0] SegBlank = 7'h00;

  typedef struct packed {
    logic signed [15:0] value;
    logic               left_align;
  } in_t;

  typedef struct packed {
    logic [SegW-1:0] digit0_segments;
    logic [SegW-1:0] digit1_segments;
    logic [SegW-1:0] digit2_segments;
    logic [SegW-1:0] digit3_segments;
    logic            out_of_range;
  } out_t;

  // Data handed from cell to cell: digits[0] is the ones digit after the last cell.
  typedef struct packed {
    logic [MagW-1:0]                    rest;
    logic [NumDigits-1:0][DigitW-1:0]   digits;
    logic [NumDigits-1:0]               sig;
    logic                               neg;
    logic                               left;
    logic                               oor;
  } pipe_t;

  function automatic logic [SegW-1:0] seg_of_digit(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

### sv/ssnf_entry.sv
// Entry stage: range check, sign and magnitude of the incoming number.
module ssnf_entry import ssnf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  in_t   item_i,
  output logic  valid_o,
  input  logic  stall_i,
  output pipe_t pipe_o
);

  logic        valid_q;
  pipe_t       pipe_d, pipe_q;
  logic [15:0] abs_val;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    abs_val        = item_i.value[15] ? 16'(-item_i.value) : 16'(item_i.value);
    pipe_d.rest    = abs_val[MagW-1:0];
    pipe_d.digits  = '0;
    pipe_d.sig     = '0;
    pipe_d.neg     = item_i.value[15];
    pipe_d.left    = item_i.left_align;
    pipe_d.oor     = (item_i.value > MaxShown) || (item_i.value < MinShown);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

### sv/ssnf_digit_cell.sv
// One cell of the digit chain: peel off the lowest decimal digit, pass the quotient on.
module ssnf_digit_cell import ssnf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  pipe_t pipe_i,
  output logic  valid_o,
  input  logic  stall_i,
  output pipe_t pipe_o
);

  logic             valid_q;
  pipe_t            pipe_d, pipe_q;
  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;
  logic [MagW-1:0]  rem;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    prod = ProdW'(pipe_i.rest) * ProdW'(RecipTen);
    quot = prod[RecipShift +: QuotW];
    // rest - 10 * quot, by shifts
    rem  = pipe_i.rest - {quot, 3'b000} - MagW'({quot, 1'b0});
    pipe_d        = pipe_i;
    pipe_d.rest   = MagW'(quot);
    // shift the new digit in at the top; the ones digit lands at index 0
    pipe_d.digits = {rem[DigitW-1:0], pipe_i.digits[NumDigits-1:1]};
    pipe_d.sig    = {(pipe_i.rest != '0), pipe_i.sig[NumDigits-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

### sv/ssnf_pack.sv
// Final stage: place minus and digits, pack left or right, decode segments.
module ssnf_pack import ssnf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  pipe_t pipe_i,
  output logic  valid_o,
  input  logic  stall_i,
  output out_t  item_o
);

  logic                       valid_q;
  out_t                       out_d, out_q;
  logic [2:0]                 ndig;
  logic [2:0]                 len;
  logic signed [3:0]          r;
  logic [NumDigits-1:0][SegW-1:0] seg;

  assign stall_o = valid_q && stall_i;

  always_comb begin
    // sig is a thermometer code; zero still shows one digit
    if (pipe_i.sig[3]) begin
      ndig = 3'd4;
    end else if (pipe_i.sig[2]) begin
      ndig = 3'd3;
    end else if (pipe_i.sig[1]) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
    len = ndig + 3'(pipe_i.neg);
    for (int p = 0; p < NumDigits; p++) begin
      // r counts group places from the right end of the group
      if (pipe_i.left) begin
        r = $signed({1'b0, len}) - 4'sd1 - $signed(4'(p));
      end else begin
        r = 4'(NumDigits - 1 - p);
      end
      if (pipe_i.oor) begin
        seg[p] = SegMinus;
      end else if (r < 4'sd0) begin
        seg[p] = SegBlank;
      end else if (r[2:0] < ndig) begin
        seg[p] = seg_of_digit(pipe_i.digits[r[1:0]]);
      end else if ((r[2:0] == ndig) && pipe_i.neg) begin
        seg[p] = SegMinus;
      end else begin
        seg[p] = SegBlank;
      end
    end
    out_d.digit0_segments = seg[0];
    out_d.digit1_segments = seg[1];
    out_d.digit2_segments = seg[2];
    out_d.digit3_segments = seg[3];
    out_d.out_of_range    = pipe_i.oor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = out_q;

endmodule

### sv/seven_segment_number_formatter.sv
// Top level of the four-digit signed seven-segment number formatter.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_item_i  (in_t)
//   out      output     out_valid_o / out_stall_i out_item_o (out_t)
//
// One item per cycle sustained while out_stall_i is low; registered stages: entry stage,
// four digit cells (one divide-by-ten multiply each) and the packing/output register.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage holds while it is full and the stage after it stalls, so bubbles
// close up and out_stall_i reaches in_stall_o only when the whole chain is full.
module seven_segment_number_formatter import ssnf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  logic  [NumDigits:0] valid;
  logic  [NumDigits:0] stall;
  pipe_t [NumDigits:0] pipe;

  ssnf_entry u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item_i),
    .valid_o (valid[0]),
    .stall_i (stall[0]),
    .pipe_o  (pipe[0])
  );

  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    ssnf_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[g]),
      .stall_o (stall[g]),
      .pipe_i  (pipe[g]),
      .valid_o (valid[g+1]),
      .stall_i (stall[g+1]),
      .pipe_o  (pipe[g+1])
    );
  end

  ssnf_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NumDigits]),
    .stall_o (stall[NumDigits]),
    .pipe_i  (pipe[NumDigits]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item_o)
  );

endmodule

### sv/ssnf_checker.sv
// Port-level checks of the number formatter, bound to the top level.
`include "seven_segment_number_formatter_defines.svh"

module ssnf_checker import ssnf_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_item_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_item_o
);

  logic [3:0] is_minus;
  logic       in_busy;
  logic       out_busy;
  logic       oor_out;
  logic       shown_out;
  logic       edge_used;

  assign is_minus = {out_item_o.digit3_segments == SegMinus,
                     out_item_o.digit2_segments == SegMinus,
                     out_item_o.digit1_segments == SegMinus,
                     out_item_o.digit0_segments == SegMinus};

  assign in_busy   = in_valid_i && in_stall_o;
  assign out_busy  = out_valid_o && out_stall_i;
  assign oor_out   = out_valid_o && out_item_o.out_of_range;
  assign shown_out = out_valid_o && !out_item_o.out_of_range;
  assign edge_used = (out_item_o.digit0_segments != SegBlank) ||
                     (out_item_o.digit3_segments != SegBlank);

  // a stalled item stays put
  `SSNF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_busy, out_valid_o && $stable(out_item_o))

  // a stalled input item stays put
  `SSNF_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_busy, in_valid_i && $stable(in_item_i))

  // out of range shows four dashes
  `SSNF_ASSERT_NOW(a_oor_dashes, clk_i, rst_ni, oor_out, is_minus == 4'hf)

  // in range shows at most one minus sign
  `SSNF_ASSERT_NOW(a_one_minus, clk_i, rst_ni, shown_out, $countones(is_minus) <= 1)

  // the group always touches one end of the display
  `SSNF_ASSERT_NOW(a_edge_used, clk_i, rst_ni, out_valid_o, edge_used)

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (.*);
